### sv/trsmb_pkg.sv
// shared constants, types and fixed-point helpers for the model matrix builder
`default_nettype none

package trsmb_pkg;

	// Q30 unity and angle constants (Q16.16 degrees)
	localparam logic [31:0] Q30_ONE     = 32'd1073741824;
	localparam logic [24:0] DEG360      = 25'd23592960;
	localparam logic [24:0] DEG90       = 25'd5898240;
	localparam logic [24:0] DEG180      = 25'd11796480;
	localparam logic [24:0] DEG270      = 25'd17694720;
	// floor(2^32 / 360 deg) for the angle wrap quotient estimate
	localparam logic [7:0]  DEG360_RECIP = 8'd182;
	// 2^31 mod 360 deg, undoes the offset that makes the angle unsigned
	localparam logic [24:0] MOD_OFS     = 25'd524288;
	// pi/180 in Q30
	localparam logic [24:0] RAD_PER_DEG = 25'd18740330;

	// translation divisor and floor(2^32 / 100)
	localparam logic [7:0]  TRANS_DIV   = 8'd100;
	localparam logic [25:0] TRANS_RECIP = 26'd42949672;

	// series steps; sine runs one idle step up front so both chains line up
	localparam int NSTEP  = 6;
	localparam int SC_LAT = 26;

	typedef logic [7:0]  div_t;
	typedef logic [32:0] recip_t;

	localparam div_t SIN_DIV [NSTEP] = '{8'd0, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam div_t COS_DIV [NSTEP] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
	// floor(2^33 / n)
	localparam recip_t SIN_RECIP [NSTEP] = '{33'd0, 33'd78090314, 33'd119304647,
		33'd204522252, 33'd429496729, 33'd1431655765};
	localparam recip_t COS_RECIP [NSTEP] = '{33'd65075262, 33'd95443717, 33'd153391689,
		33'd286331153, 33'd715827882, 33'd4294967296};

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam logic [1:0] COL_0    = 2'd0;
	localparam logic [1:0] COL_1    = 2'd1;
	localparam logic [1:0] COL_2    = 2'd2;
	localparam logic [1:0] COL_LAST = 2'd3;

	localparam logic signed [31:0] ROW3_ONE = 32'sd65536;

	typedef logic signed [31:0] q16_t;

	typedef struct packed {
		q16_t x;
		q16_t y;
		q16_t z;
	} vec3_t;

	// values that ride along the series chain
	typedef struct packed {
		logic [30:0] x;
		logic [31:0] x2;
		logic [1:0]  quad;
	} sc_carry_t;

	// divide by 2^30, truncating toward zero
	function automatic logic signed [35:0] q30_trunc(input logic signed [65:0] p);
		logic signed [65:0] b;
		b = p + (p[65] ? 66'sd1073741823 : 66'sd0);
		return 36'(b >>> 30);
	endfunction

	function automatic q16_t sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -36'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

`default_nettype wire

### sv/trs_model_matrix_builder.sv
// top level: builds the 4x4 model matrix T*Rx*Ry*Rz*S and streams it by columns
//
//   channel  direction  handshake              payload
//   in       into block in_valid / in_stall    pos_*, angle_*, scale_* (Q16.16)
//   out      from block out_valid / out_stall  column_index, elem_row0..3, last_column
//
// every transform yields four column transactions, one per cycle unless out_stall holds
// them, and the output serializer takes the next matrix as the last column leaves; the
// path from input acceptance to the first column runs through 26 sine/cosine stages,
// 6 matrix stages and one output register
// reset clears only valid bits and the column counter; data registers are not reset
// a stall freezes the whole pipeline in place, nothing is dropped or repeated
`default_nettype none

module trs_model_matrix_builder import trsmb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] angle_x,
	input  logic signed [31:0] angle_y,
	input  logic signed [31:0] angle_z,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] scale_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         column_index,
	output logic signed [31:0] elem_row0,
	output logic signed [31:0] elem_row1,
	output logic signed [31:0] elem_row2,
	output logic signed [31:0] elem_row3,
	output logic               last_column
);

	// pipeline advance and serializer load
	logic en;
	logic ld;

	// sine/cosine outputs, aligned with stage SC_LAT
	logic signed [31:0] sx, cx, sy, cy, sz, cz;

	// valid bits and operands riding beside the sine/cosine pipe
	logic [SC_LAT-1:0] sc_v_s;
	vec3_t pos_s [1:SC_LAT];
	vec3_t scl_s [1:SC_LAT];

	logic v_s27, v_s28, v_s29, v_s30, v_s31, v_s32;

	// stage 27: first products, magnitude of position
	logic signed [63:0] cycz_s27, cysz_s27, cxsz_s27, cxcz_s27, sxsy_s27;
	logic signed [63:0] cxsy_s27, sxcy_s27, sxsz_s27, sxcz_s27, cxcy_s27;
	logic signed [31:0] sy_s27, sz_s27, cz_s27;
	logic [31:0] pa_s27 [3];
	logic [2:0]  neg_s27;
	vec3_t       scl_s27;

	// stage 28: truncated products, translation quotient estimate
	logic signed [31:0] cycz_s28, cysz_s28, cxsz_s28, cxcz_s28, sxsy_s28;
	logic signed [31:0] cxsy_s28, sxcy_s28, sxsz_s28, sxcz_s28, cxcy_s28;
	logic signed [31:0] sy_s28, sz_s28, cz_s28;
	logic [31:0] pa_s28 [3];
	logic [25:0] tq_s28 [3];
	logic [2:0]  neg_s28;
	vec3_t       scl_s28;

	// stage 29: triple products, translation done
	logic signed [63:0] sxsycz_s29, sxsysz_s29, cxsycz_s29, cxsysz_s29;
	logic signed [31:0] cycz_s29, cysz_s29, cxsz_s29, cxcz_s29;
	logic signed [31:0] sxcy_s29, sxsz_s29, sxcz_s29, cxcy_s29, sy_s29;
	vec3_t scl_s29;
	vec3_t tr_s29;

	// stages 30..32: rotation, scaled products, saturated matrix
	logic signed [32:0] rot_s30 [3][3];
	logic signed [65:0] sp_s31  [3][3];
	q16_t               mat_s32 [3][3];
	vec3_t scl_s30;
	vec3_t tr_s30, tr_s31, tr_s32;

	// output serializer
	logic  out_v_q;
	logic [1:0] col_q;
	q16_t  omat_q [3][3];
	vec3_t otr_q;

	logic [32:0] tq_rem [3];
	logic [25:0] tq     [3];

	// whole pipe moves unless the tail holds a matrix the serializer cannot take
	assign ld       = v_s32 && (!out_v_q || (!out_stall && col_q == COL_LAST));
	assign en       = !v_s32 || ld;
	assign in_stall = !en;

	trsmb_sincos u_sc_x (.clk(clk), .en(en), .angle(angle_x), .sine(sx), .cosine(cx));
	trsmb_sincos u_sc_y (.clk(clk), .en(en), .angle(angle_y), .sine(sy), .cosine(cy));
	trsmb_sincos u_sc_z (.clk(clk), .en(en), .angle(angle_z), .sine(sz), .cosine(cz));

	// valid bits follow the data through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_v_s <= '0;
			v_s27  <= 1'b0;
			v_s28  <= 1'b0;
			v_s29  <= 1'b0;
			v_s30  <= 1'b0;
			v_s31  <= 1'b0;
			v_s32  <= 1'b0;
		end else if (en) begin
			sc_v_s <= {sc_v_s[SC_LAT-2:0], in_valid};
			v_s27  <= sc_v_s[SC_LAT-1];
			v_s28  <= v_s27;
			v_s29  <= v_s28;
			v_s30  <= v_s29;
			v_s31  <= v_s30;
			v_s32  <= v_s31;
		end
	end

	// position and scale wait for the angles
	always_ff @(posedge clk) begin
		if (en) begin
			pos_s[1] <= '{x: pos_x, y: pos_y, z: pos_z};
			scl_s[1] <= '{x: scale_x, y: scale_y, z: scale_z};
			for (int k = 2; k <= SC_LAT; k++) begin
				pos_s[k] <= pos_s[k-1];
				scl_s[k] <= scl_s[k-1];
			end
		end
	end

	// translation: exact correction of the reciprocal estimate, sign restored
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tq_rem[i] = 33'(pa_s28[i]) - 33'(33'(tq_s28[i]) * 33'(TRANS_DIV));
			tq[i]     = tq_s28[i] + ((tq_rem[i] >= 33'(TRANS_DIV)) ? 26'd1 : 26'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 27
			cycz_s27 <= 64'(cy) * 64'(cz);
			cysz_s27 <= 64'(cy) * 64'(sz);
			cxsz_s27 <= 64'(cx) * 64'(sz);
			cxcz_s27 <= 64'(cx) * 64'(cz);
			sxsy_s27 <= 64'(sx) * 64'(sy);
			cxsy_s27 <= 64'(cx) * 64'(sy);
			sxcy_s27 <= 64'(sx) * 64'(cy);
			sxsz_s27 <= 64'(sx) * 64'(sz);
			sxcz_s27 <= 64'(sx) * 64'(cz);
			cxcy_s27 <= 64'(cx) * 64'(cy);
			sy_s27   <= sy;
			sz_s27   <= sz;
			cz_s27   <= cz;
			pa_s27[0] <= pos_s[SC_LAT].x[31] ? 32'(-pos_s[SC_LAT].x) : 32'(pos_s[SC_LAT].x);
			pa_s27[1] <= pos_s[SC_LAT].y[31] ? 32'(-pos_s[SC_LAT].y) : 32'(pos_s[SC_LAT].y);
			pa_s27[2] <= pos_s[SC_LAT].z[31] ? 32'(-pos_s[SC_LAT].z) : 32'(pos_s[SC_LAT].z);
			neg_s27  <= {pos_s[SC_LAT].z[31], pos_s[SC_LAT].y[31], pos_s[SC_LAT].x[31]};
			scl_s27  <= scl_s[SC_LAT];

			// stage 28
			cycz_s28 <= 32'(q30_trunc(66'(cycz_s27)));
			cysz_s28 <= 32'(q30_trunc(66'(cysz_s27)));
			cxsz_s28 <= 32'(q30_trunc(66'(cxsz_s27)));
			cxcz_s28 <= 32'(q30_trunc(66'(cxcz_s27)));
			sxsy_s28 <= 32'(q30_trunc(66'(sxsy_s27)));
			cxsy_s28 <= 32'(q30_trunc(66'(cxsy_s27)));
			sxcy_s28 <= 32'(q30_trunc(66'(sxcy_s27)));
			sxsz_s28 <= 32'(q30_trunc(66'(sxsz_s27)));
			sxcz_s28 <= 32'(q30_trunc(66'(sxcz_s27)));
			cxcy_s28 <= 32'(q30_trunc(66'(cxcy_s27)));
			sy_s28   <= sy_s27;
			sz_s28   <= sz_s27;
			cz_s28   <= cz_s27;
			for (int i = 0; i < 3; i++) begin
				pa_s28[i] <= pa_s27[i];
				tq_s28[i] <= 26'((58'(pa_s27[i]) * 58'(TRANS_RECIP)) >> 32);
			end
			neg_s28  <= neg_s27;
			scl_s28  <= scl_s27;

			// stage 29
			sxsycz_s29 <= 64'(sxsy_s28) * 64'(cz_s28);
			sxsysz_s29 <= 64'(sxsy_s28) * 64'(sz_s28);
			cxsycz_s29 <= 64'(cxsy_s28) * 64'(cz_s28);
			cxsysz_s29 <= 64'(cxsy_s28) * 64'(sz_s28);
			cycz_s29 <= cycz_s28;
			cysz_s29 <= cysz_s28;
			cxsz_s29 <= cxsz_s28;
			cxcz_s29 <= cxcz_s28;
			sxcy_s29 <= sxcy_s28;
			sxsz_s29 <= sxsz_s28;
			sxcz_s29 <= sxcz_s28;
			cxcy_s29 <= cxcy_s28;
			sy_s29   <= sy_s28;
			scl_s29  <= scl_s28;
			tr_s29.x <= neg_s28[0] ? -32'(tq[0]) : 32'(tq[0]);
			tr_s29.y <= neg_s28[1] ? -32'(tq[1]) : 32'(tq[1]);
			tr_s29.z <= neg_s28[2] ? -32'(tq[2]) : 32'(tq[2]);

			// stage 30: rotation entries
			rot_s30[0][0] <= 33'(cycz_s29);
			rot_s30[0][1] <= -33'(cysz_s29);
			rot_s30[0][2] <= 33'(sy_s29);
			rot_s30[1][0] <= 33'(cxsz_s29) + 33'(q30_trunc(66'(sxsycz_s29)));
			rot_s30[1][1] <= 33'(cxcz_s29) - 33'(q30_trunc(66'(sxsysz_s29)));
			rot_s30[1][2] <= -33'(sxcy_s29);
			rot_s30[2][0] <= 33'(sxsz_s29) - 33'(q30_trunc(66'(cxsycz_s29)));
			rot_s30[2][1] <= 33'(sxcz_s29) + 33'(q30_trunc(66'(cxsysz_s29)));
			rot_s30[2][2] <= 33'(cxcy_s29);
			scl_s30 <= scl_s29;
			tr_s30  <= tr_s29;

			// stage 31: column j scaled by scale j
			for (int r = 0; r < 3; r++) begin
				sp_s31[r][0] <= 66'(rot_s30[r][0]) * 66'(scl_s30.x);
				sp_s31[r][1] <= 66'(rot_s30[r][1]) * 66'(scl_s30.y);
				sp_s31[r][2] <= 66'(rot_s30[r][2]) * 66'(scl_s30.z);
			end
			tr_s31 <= tr_s30;

			// stage 32: back to Q16.16 with saturation
			for (int r = 0; r < 3; r++)
				for (int j = 0; j < 3; j++)
					mat_s32[r][j] <= sat32(q30_trunc(sp_s31[r][j]));
			tr_s32 <= tr_s31;
		end
	end

	// serializer control: one column per accepted output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			col_q   <= COL_0;
		end else if (ld) begin
			out_v_q <= 1'b1;
			col_q   <= COL_0;
		end else if (out_v_q && !out_stall) begin
			if (col_q == COL_LAST)
				out_v_q <= 1'b0;
			else
				col_q <= col_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			omat_q <= mat_s32;
			otr_q  <= tr_s32;
		end
	end

	assign out_valid    = out_v_q;
	assign column_index = col_q;
	assign last_column  = (col_q == COL_LAST);

	always_comb begin
		unique case (col_q)
			COL_0: begin
				elem_row0 = omat_q[0][0];
				elem_row1 = omat_q[1][0];
				elem_row2 = omat_q[2][0];
				elem_row3 = '0;
			end
			COL_1: begin
				elem_row0 = omat_q[0][1];
				elem_row1 = omat_q[1][1];
				elem_row2 = omat_q[2][1];
				elem_row3 = '0;
			end
			COL_2: begin
				elem_row0 = omat_q[0][2];
				elem_row1 = omat_q[1][2];
				elem_row2 = omat_q[2][2];
				elem_row3 = '0;
			end
			default: begin
				// translation column
				elem_row0 = otr_q.x;
				elem_row1 = otr_q.y;
				elem_row2 = otr_q.z;
				elem_row3 = ROW3_ONE;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/trsmb_sincos.sv
// pipelined sine and cosine of a Q16.16 degree angle, Q30 results
`default_nettype none

module trsmb_sincos import trsmb_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] angle,
	output logic signed [31:0] sine,
	output logic signed [31:0] cosine
);

	logic [31:0] u;
	logic [31:0] u_s1;
	logic [7:0]  q0_s1;
	logic [32:0] rem_c;
	logic [24:0] rem_s2;
	logic [24:0] a_s3;
	logic [1:0]  quad_s4;
	logic [22:0] r_s4;
	logic [1:0]  quad_s5;
	logic [30:0] x_s5;
	sc_carry_t   car_s6;

	logic [62:0]        ps_a  [NSTEP];
	logic [62:0]        pc_a  [NSTEP];
	sc_carry_t          car_a [NSTEP];
	logic [32:0]        vs_b  [NSTEP];
	logic [32:0]        qs_b  [NSTEP];
	logic [32:0]        vc_b  [NSTEP];
	logic [32:0]        qc_b  [NSTEP];
	sc_carry_t          car_b [NSTEP];
	logic signed [31:0] ts_c  [NSTEP];
	logic signed [31:0] tc_c  [NSTEP];
	sc_carry_t          car_c [NSTEP];

	logic signed [31:0] sm_s25;
	logic signed [31:0] cm_s25;
	logic [1:0]         quad_s25;

	// offset binary makes the angle unsigned
	assign u = {~angle[31], angle[30:0]};
	assign rem_c = {1'b0, u_s1} - 33'(33'(q0_s1) * 33'(DEG360));

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= u;
			q0_s1 <= 8'((40'(u) * 40'(DEG360_RECIP)) >> 32);
			rem_s2 <= (rem_c >= 33'(DEG360)) ? 25'(rem_c - 33'(DEG360)) : 25'(rem_c);
			a_s3 <= (rem_s2 >= MOD_OFS) ? (rem_s2 - MOD_OFS)
				: 25'(26'(rem_s2) + 26'(DEG360) - 26'(MOD_OFS));
			if (a_s3 < DEG90) begin
				quad_s4 <= QUAD_0;
				r_s4    <= 23'(a_s3);
			end else if (a_s3 < DEG180) begin
				quad_s4 <= QUAD_1;
				r_s4    <= 23'(a_s3 - DEG90);
			end else if (a_s3 < DEG270) begin
				quad_s4 <= QUAD_2;
				r_s4    <= 23'(a_s3 - DEG180);
			end else begin
				quad_s4 <= QUAD_3;
				r_s4    <= 23'(a_s3 - DEG270);
			end
			quad_s5 <= quad_s4;
			x_s5    <= 31'((48'(r_s4) * 48'(RAD_PER_DEG)) >> 16);
			car_s6.x    <= x_s5;
			car_s6.x2   <= 32'((62'(x_s5) * 62'(x_s5)) >> 30);
			car_s6.quad <= quad_s5;
		end
	end

	// each series step: product, reciprocal estimate, correction
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic [30:0] ts_in;
		logic [30:0] tc_in;
		sc_carry_t   car_in;
		logic [33:0] rs;
		logic [33:0] rc;
		logic [32:0] qs;
		logic [32:0] qc;

		if (k == 0) begin : g_first
			assign ts_in  = Q30_ONE[30:0];
			assign tc_in  = Q30_ONE[30:0];
			assign car_in = car_s6;
		end else begin : g_next
			assign ts_in  = ts_c[k-1][30:0];
			assign tc_in  = tc_c[k-1][30:0];
			assign car_in = car_c[k-1];
		end

		assign rs = 34'(vs_b[k]) - 34'(34'(qs_b[k]) * 34'(SIN_DIV[k]));
		assign rc = 34'(vc_b[k]) - 34'(34'(qc_b[k]) * 34'(COS_DIV[k]));
		assign qs = qs_b[k] + ((rs >= 34'(SIN_DIV[k])) ? 33'd1 : 33'd0);
		assign qc = qc_b[k] + ((rc >= 34'(COS_DIV[k])) ? 33'd1 : 33'd0);

		always_ff @(posedge clk) begin
			if (en) begin
				ps_a[k]  <= 63'(car_in.x2) * 63'(ts_in);
				pc_a[k]  <= 63'(car_in.x2) * 63'(tc_in);
				car_a[k] <= car_in;
				vs_b[k]  <= ps_a[k][62:30];
				vc_b[k]  <= pc_a[k][62:30];
				qs_b[k]  <= 33'((66'(ps_a[k][62:30]) * 66'(SIN_RECIP[k])) >> 33);
				qc_b[k]  <= 33'((66'(pc_a[k][62:30]) * 66'(COS_RECIP[k])) >> 33);
				car_b[k] <= car_a[k];
				if (SIN_DIV[k] == 8'd0)
					ts_c[k] <= Q30_ONE;
				else
					ts_c[k] <= 32'(34'(Q30_ONE) - 34'(qs));
				tc_c[k]  <= 32'(34'(Q30_ONE) - 34'(qc));
				car_c[k] <= car_b[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sm_s25   <= 32'((62'(car_c[NSTEP-1].x) * 62'(ts_c[NSTEP-1][30:0])) >> 30);
			cm_s25   <= tc_c[NSTEP-1];
			quad_s25 <= car_c[NSTEP-1].quad;
			unique case (quad_s25)
				QUAD_0: begin
					sine   <= sm_s25;
					cosine <= cm_s25;
				end
				QUAD_1: begin
					sine   <= cm_s25;
					cosine <= -sm_s25;
				end
				QUAD_2: begin
					sine   <= -sm_s25;
					cosine <= -cm_s25;
				end
				default: begin
					sine   <= -cm_s25;
					cosine <= sm_s25;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
